@@ hdl/ffra_pkg.sv @@
package ffra_pkg;

	localparam int SLOT_W = 16;
	localparam int LEN_W = 17;
	localparam int SUM_W = 18;
	localparam int STATUS_W = 3;
	localparam int TDATA_W = 40;

	localparam logic [LEN_W-1:0] MAX_CAP = 17'h10000;

	localparam logic OP_RESERVE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 3'd0,
		STS_NO_FIT  = 3'd1,
		STS_BAD_REL = 3'd2,
		STS_ZERO    = 3'd3,
		STS_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic [SLOT_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} range_t;

	typedef enum logic [2:0] {
		TBL_NOP   = 3'd0,
		TBL_READ  = 3'd1,
		TBL_WRITE = 3'd2,
		TBL_DEL   = 3'd3,
		TBL_INS   = 3'd4,
		TBL_INIT  = 3'd5,
		TBL_CLEAR = 3'd6
	} tbl_op_t;

	typedef struct packed {
		tbl_op_t op;
		range_t  data;
	} tbl_cmd_t;

	typedef struct packed {
		range_t rdata;
		logic   busy;
	} tbl_stat_t;

endpackage

@@ hdl/ffra_table.sv @@
module ffra_table import ffra_pkg::*; #(
	parameter int MAX_RANGES = 64,
	localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
	localparam int CNT_W = $clog2(MAX_RANGES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tbl_cmd_t         cmd,
	input  logic [CNT_W-1:0] cmd_addr,
	output tbl_stat_t        stat,
	output logic [CNT_W-1:0] cnt
);

	typedef enum logic [2:0] {
		SH_IDLE = 3'b001,
		SH_DEL  = 3'b010,
		SH_INS  = 3'b100
	} sh_state_t;

	range_t           mem [MAX_RANGES];
	range_t           rdata_q;
	range_t           ins_q;
	sh_state_t        sh_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] pend_addr_q;
	logic             pend_q;

	logic             we;
	logic             re;
	logic [CNT_W-1:0] waddr;
	logic [CNT_W-1:0] raddr;
	range_t           wdata;
	logic             room;

	assign room = cnt_q < CNT_W'(MAX_RANGES);

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		waddr = cmd_addr;
		raddr = cmd_addr;
		wdata = cmd.data;
		case (sh_q)
			SH_IDLE: begin
				case (cmd.op)
					TBL_READ: re = 1'b1;
					TBL_WRITE: we = 1'b1;
					TBL_INS: we = room && (cmd_addr == cnt_q);
					TBL_INIT: begin
						we = 1'b1;
						waddr = '0;
					end
					default: ;
				endcase
			end
			SH_DEL: begin
				if (pend_q) begin
					we = 1'b1;
					waddr = pend_addr_q;
					wdata = rdata_q;
				end
				if (ptr_q < cnt_q) begin
					re = 1'b1;
					raddr = ptr_q;
				end
			end
			SH_INS: begin
				if (pend_q) begin
					we = 1'b1;
					waddr = pend_addr_q;
					wdata = rdata_q;
				end else if (ptr_q == pos_q) begin
					we = 1'b1;
					waddr = pos_q;
					wdata = ins_q;
				end
				if (ptr_q > pos_q) begin
					re = 1'b1;
					raddr = ptr_q - CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[IDX_W-1:0]] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr[IDX_W-1:0]];
		end
		if (sh_q == SH_IDLE && cmd.op == TBL_INS) begin
			ins_q <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= SH_IDLE;
			cnt_q <= '0;
			ptr_q <= '0;
			pos_q <= '0;
			pend_q <= 1'b0;
			pend_addr_q <= '0;
		end else begin
			case (sh_q)
				SH_IDLE: begin
					pend_q <= 1'b0;
					case (cmd.op)
						TBL_DEL: begin
							if (cmd_addr < cnt_q) begin
								sh_q <= SH_DEL;
								ptr_q <= cmd_addr + CNT_W'(1);
							end
						end
						TBL_INS: begin
							if (room && cmd_addr == cnt_q) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end else if (room && cmd_addr < cnt_q) begin
								sh_q <= SH_INS;
								ptr_q <= cnt_q;
								pos_q <= cmd_addr;
							end
						end
						TBL_INIT: cnt_q <= CNT_W'(1);
						TBL_CLEAR: cnt_q <= '0;
						default: ;
					endcase
				end
				SH_DEL: begin
					pend_q <= re;
					pend_addr_q <= ptr_q - CNT_W'(1);
					if (re) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end else if (!pend_q) begin
						cnt_q <= cnt_q - CNT_W'(1);
						sh_q <= SH_IDLE;
					end
				end
				SH_INS: begin
					pend_q <= re;
					pend_addr_q <= ptr_q;
					if (re) begin
						ptr_q <= ptr_q - CNT_W'(1);
					end else if (!pend_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
						sh_q <= SH_IDLE;
					end
				end
				default: sh_q <= SH_IDLE;
			endcase
		end
	end

	assign stat.rdata = rdata_q;
	assign stat.busy = (sh_q != SH_IDLE);
	assign cnt = cnt_q;

endmodule

@@ hdl/ffra_ctrl.sv @@
module ffra_ctrl import ffra_pkg::*; #(
	parameter int MAX_RANGES = 64,
	localparam int CNT_W = $clog2(MAX_RANGES + 1),
	localparam int TOT_W = CNT_W + 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               s_tuser,
	input  logic [SLOT_W-1:0]  in_start,
	input  logic [LEN_W-1:0]   in_count,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [STATUS_W-1:0] out_status,
	output logic [SLOT_W-1:0]  out_granted,
	output logic [LEN_W-1:0]   out_in_use,
	input  logic               cfg_we,
	input  logic [LEN_W-1:0]   cfg_data,
	output tbl_cmd_t           free_cmd,
	output logic [CNT_W-1:0]   free_addr,
	input  tbl_stat_t          free_stat,
	input  logic [CNT_W-1:0]   free_cnt,
	output tbl_cmd_t           used_cmd,
	output logic [CNT_W-1:0]   used_addr,
	input  tbl_stat_t          used_stat,
	input  logic [CNT_W-1:0]   used_cnt
);

	typedef enum logic [13:0] {
		CS_INIT     = 14'b00000000000001,
		CS_IDLE     = 14'b00000000000010,
		CS_SCANA_RD = 14'b00000000000100,
		CS_SCANA_CK = 14'b00000000001000,
		CS_SCANB_RD = 14'b00000000010000,
		CS_SCANB_CK = 14'b00000000100000,
		CS_PLAN     = 14'b00000001000000,
		CS_APA      = 14'b00000010000000,
		CS_APA2     = 14'b00000100000000,
		CS_WAITA    = 14'b00001000000000,
		CS_APB      = 14'b00010000000000,
		CS_APB2     = 14'b00100000000000,
		CS_WAITB    = 14'b01000000000000,
		CS_DONE     = 14'b10000000000000
	} cs_state_t;

	cs_state_t         state_q;
	logic [LEN_W-1:0]  cap_q;
	logic              op_q;
	logic [SLOT_W-1:0] s_q;
	logic [LEN_W-1:0]  n_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  hit_idx_q;
	logic [SLOT_W-1:0] hit_start_q;
	logic [LEN_W-1:0]  before_q;
	logic [LEN_W-1:0]  after_q;
	logic              del_a_q;
	logic              split_a_q;
	range_t            prev_q;
	range_t            next_q;
	logic              have_prev_q;
	logic              mn_q;
	logic              mp_q;
	status_t           res_status_q;
	logic [SLOT_W-1:0] res_granted_q;
	logic [LEN_W-1:0]  used_total_q;
	logic              m_tvalid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0] out_granted_q;
	logic [LEN_W-1:0]  out_in_use_q;

	tbl_stat_t         a_stat;
	tbl_stat_t         b_stat;
	logic [CNT_W-1:0]  a_cnt;
	logic [CNT_W-1:0]  b_cnt;
	tbl_cmd_t          a_cmd;
	tbl_cmd_t          b_cmd;
	logic [CNT_W-1:0]  a_addr;
	logic [CNT_W-1:0]  b_addr;

	range_t            ea;
	logic [SUM_W-1:0]  ea_end;
	logic [SUM_W-1:0]  req_end;
	logic              a_hit;
	logic              rel_fits;
	logic [SLOT_W-1:0] base_s;
	logic [LEN_W-1:0]  before_c;
	logic [LEN_W-1:0]  after_c;
	logic              mp_c;
	logic [TOT_W-1:0]  tot;
	logic [TOT_W-1:0]  t1;
	logic [TOT_W-1:0]  t2;
	logic              full_c;
	logic [SLOT_W-1:0] split_start;
	logic [LEN_W-1:0]  cfg_sat;
	logic              out_free;

	assign a_stat = (op_q == OP_RELEASE) ? used_stat : free_stat;
	assign b_stat = (op_q == OP_RELEASE) ? free_stat : used_stat;
	assign a_cnt = (op_q == OP_RELEASE) ? used_cnt : free_cnt;
	assign b_cnt = (op_q == OP_RELEASE) ? free_cnt : used_cnt;

	assign ea = a_stat.rdata;
	assign ea_end = SUM_W'(ea.start) + SUM_W'(ea.len);
	assign req_end = SUM_W'(s_q) + SUM_W'(n_q);
	assign a_hit = (op_q == OP_RESERVE) ? (ea.len >= n_q)
		: ((s_q >= ea.start) && (SUM_W'(s_q) < ea_end));
	assign rel_fits = req_end <= ea_end;
	assign base_s = (op_q == OP_RESERVE) ? ea.start : s_q;
	assign before_c = (op_q == OP_RESERVE) ? '0 : LEN_W'(s_q - ea.start);
	assign after_c = LEN_W'(ea_end - (SUM_W'(base_s) + SUM_W'(n_q)));

	assign mp_c = have_prev_q
		&& (SUM_W'(prev_q.start) + SUM_W'(prev_q.len) == SUM_W'(s_q));
	assign tot = TOT_W'(free_cnt) + TOT_W'(used_cnt);
	assign t1 = tot + TOT_W'(split_a_q) - TOT_W'(del_a_q);
	assign t2 = t1 + TOT_W'(!mp_c && !mn_q) - TOT_W'(mp_c && mn_q);
	assign full_c = (t1 > TOT_W'(MAX_RANGES)) || (t2 > TOT_W'(MAX_RANGES));
	assign split_start = SLOT_W'(req_end);

	assign cfg_sat = (cfg_data > MAX_CAP) ? MAX_CAP : cfg_data;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		a_cmd.op = TBL_NOP;
		a_cmd.data = '0;
		a_addr = hit_idx_q;
		b_cmd.op = TBL_NOP;
		b_cmd.data = '0;
		b_addr = idx_q;
		case (state_q)
			CS_SCANA_RD: begin
				a_addr = idx_q;
				if (idx_q < a_cnt) begin
					a_cmd.op = TBL_READ;
				end
			end
			CS_SCANB_RD: begin
				if (idx_q < b_cnt) begin
					b_cmd.op = TBL_READ;
				end
			end
			CS_APA: begin
				if (del_a_q) begin
					a_cmd.op = TBL_DEL;
				end else if (before_q == '0) begin
					a_cmd.op = TBL_WRITE;
					a_cmd.data = '{start: split_start, len: after_q};
				end else begin
					a_cmd.op = TBL_WRITE;
					a_cmd.data = '{start: hit_start_q, len: before_q};
				end
			end
			CS_APA2: begin
				a_cmd.op = TBL_INS;
				a_addr = hit_idx_q + CNT_W'(1);
				a_cmd.data = '{start: split_start, len: after_q};
			end
			CS_APB: begin
				if (mp_q) begin
					b_cmd.op = TBL_WRITE;
					b_addr = idx_q - CNT_W'(1);
					b_cmd.data.start = prev_q.start;
					b_cmd.data.len = mn_q ? (prev_q.len + n_q + next_q.len)
						: (prev_q.len + n_q);
				end else if (mn_q) begin
					b_cmd.op = TBL_WRITE;
					b_cmd.data = '{start: next_q.start - SLOT_W'(n_q),
						len: next_q.len + n_q};
				end else begin
					b_cmd.op = TBL_INS;
					b_cmd.data = '{start: s_q, len: n_q};
				end
			end
			CS_APB2: b_cmd.op = TBL_DEL;
			default: ;
		endcase
	end

	always_comb begin
		free_cmd = (op_q == OP_RELEASE) ? b_cmd : a_cmd;
		free_addr = (op_q == OP_RELEASE) ? b_addr : a_addr;
		used_cmd = (op_q == OP_RELEASE) ? a_cmd : b_cmd;
		used_addr = (op_q == OP_RELEASE) ? a_addr : b_addr;
		if (state_q == CS_INIT) begin
			free_cmd.op = TBL_INIT;
			free_cmd.data = '{start: '0, len: cap_q};
			free_addr = '0;
			used_cmd.op = TBL_CLEAR;
			used_cmd.data = '0;
			used_addr = '0;
		end
	end

	assign s_tready = (state_q == CS_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_INIT;
			cap_q <= MAX_CAP;
			op_q <= OP_RESERVE;
			idx_q <= '0;
			hit_idx_q <= '0;
			del_a_q <= 1'b0;
			split_a_q <= 1'b0;
			have_prev_q <= 1'b0;
			mn_q <= 1'b0;
			mp_q <= 1'b0;
			used_total_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				CS_INIT: begin
					used_total_q <= '0;
					state_q <= CS_IDLE;
				end
				CS_IDLE: begin
					if (s_tvalid) begin
						op_q <= s_tuser;
						idx_q <= '0;
						have_prev_q <= 1'b0;
						state_q <= (in_count == '0) ? CS_DONE : CS_SCANA_RD;
					end
				end
				CS_SCANA_RD: begin
					state_q <= (idx_q < a_cnt) ? CS_SCANA_CK : CS_DONE;
				end
				CS_SCANA_CK: begin
					if (!a_hit) begin
						idx_q <= idx_q + CNT_W'(1);
						state_q <= CS_SCANA_RD;
					end else if (op_q == OP_RELEASE && !rel_fits) begin
						state_q <= CS_DONE;
					end else begin
						hit_idx_q <= idx_q;
						del_a_q <= (before_c == '0) && (after_c == '0);
						split_a_q <= (before_c != '0) && (after_c != '0);
						idx_q <= '0;
						state_q <= CS_SCANB_RD;
					end
				end
				CS_SCANB_RD: begin
					if (idx_q < b_cnt) begin
						state_q <= CS_SCANB_CK;
					end else begin
						mn_q <= 1'b0;
						state_q <= CS_PLAN;
					end
				end
				CS_SCANB_CK: begin
					if (b_stat.rdata.start < s_q) begin
						have_prev_q <= 1'b1;
						idx_q <= idx_q + CNT_W'(1);
						state_q <= CS_SCANB_RD;
					end else begin
						mn_q <= (req_end == SUM_W'(b_stat.rdata.start));
						state_q <= CS_PLAN;
					end
				end
				CS_PLAN: begin
					mp_q <= mp_c;
					state_q <= full_c ? CS_DONE : CS_APA;
				end
				CS_APA: state_q <= split_a_q ? CS_APA2 : CS_WAITA;
				CS_APA2: state_q <= CS_WAITA;
				CS_WAITA: begin
					if (!a_stat.busy) begin
						state_q <= CS_APB;
					end
				end
				CS_APB: state_q <= (mp_q && mn_q) ? CS_APB2 : CS_WAITB;
				CS_APB2: state_q <= CS_WAITB;
				CS_WAITB: begin
					if (!b_stat.busy) begin
						if (op_q == OP_RESERVE) begin
							used_total_q <= used_total_q + n_q;
						end else begin
							used_total_q <= (used_total_q >= n_q) ? (used_total_q - n_q) : '0;
						end
						state_q <= CS_DONE;
					end
				end
				CS_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q <= CS_IDLE;
					end
				end
				default: state_q <= CS_INIT;
			endcase
			if (cfg_we) begin
				cap_q <= cfg_sat;
				state_q <= CS_INIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CS_IDLE: begin
				s_q <= in_start;
				n_q <= in_count;
				res_granted_q <= '0;
				res_status_q <= (in_count == '0) ? STS_ZERO : STS_OK;
			end
			CS_SCANA_RD: begin
				if (idx_q >= a_cnt) begin
					res_status_q <= (op_q == OP_RESERVE) ? STS_NO_FIT : STS_BAD_REL;
				end
			end
			CS_SCANA_CK: begin
				if (a_hit && op_q == OP_RELEASE && !rel_fits) begin
					res_status_q <= STS_BAD_REL;
				end
				if (a_hit) begin
					s_q <= base_s;
					hit_start_q <= ea.start;
					before_q <= before_c;
					after_q <= after_c;
				end
			end
			CS_SCANB_CK: begin
				if (b_stat.rdata.start < s_q) begin
					prev_q <= b_stat.rdata;
				end else begin
					next_q <= b_stat.rdata;
				end
			end
			CS_PLAN: begin
				if (full_c) begin
					res_status_q <= STS_FULL;
				end
			end
			CS_WAITB: begin
				if (op_q == OP_RESERVE) begin
					res_granted_q <= s_q;
				end
			end
			CS_DONE: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_granted_q <= res_granted_q;
					out_in_use_q <= used_total_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign out_status = out_status_q;
	assign out_granted = out_granted_q;
	assign out_in_use = out_in_use_q;

endmodule

@@ hdl/first_fit_range_allocator.sv @@
// First-fit slot allocator: each request item reserves the lowest-addressed free run that is
// large enough, or releases a run lying inside one reserved run, and returns one result item
// with a status code, the granted first slot and the slots now in use. The free and used range
// tables each sit in a single-port-read memory, so a request walks them one entry at a time, with
// a read state and a check state per entry, and shifts entries one per cycle when a range is
// inserted or removed. After reset or a write of the capacity register the block rebuilds the
// tables in its init state before it takes the next item.
module first_fit_range_allocator import ffra_pkg::*; #(
	parameter int MAX_RANGES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // block_start, block_count
	input  logic [0:0]         s_tuser,  // opcode
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // granted_start, slots_in_use
	output logic [STATUS_W-1:0] m_tuser, // status
	input  logic               cfg_we,
	input  logic [LEN_W-1:0]   cfg_data
);

	localparam int CNT_W = $clog2(MAX_RANGES + 1);

	tbl_cmd_t          free_cmd;
	tbl_cmd_t          used_cmd;
	tbl_stat_t         free_stat;
	tbl_stat_t         used_stat;
	logic [CNT_W-1:0]  free_addr;
	logic [CNT_W-1:0]  used_addr;
	logic [CNT_W-1:0]  free_cnt;
	logic [CNT_W-1:0]  used_cnt;
	logic [SLOT_W-1:0] granted;
	logic [LEN_W-1:0]  in_use;

	ffra_table #(.MAX_RANGES(MAX_RANGES)) u_free (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (free_cmd),
		.cmd_addr (free_addr),
		.stat     (free_stat),
		.cnt      (free_cnt)
	);

	ffra_table #(.MAX_RANGES(MAX_RANGES)) u_used (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (used_cmd),
		.cmd_addr (used_addr),
		.stat     (used_stat),
		.cnt      (used_cnt)
	);

	ffra_ctrl #(.MAX_RANGES(MAX_RANGES)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser[0]),
		.in_start    (s_tdata[SLOT_W-1:0]),
		.in_count    (s_tdata[SLOT_W+LEN_W-1:SLOT_W]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.out_status  (m_tuser),
		.out_granted (granted),
		.out_in_use  (in_use),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.free_cmd    (free_cmd),
		.free_addr   (free_addr),
		.free_stat   (free_stat),
		.free_cnt    (free_cnt),
		.used_cmd    (used_cmd),
		.used_addr   (used_addr),
		.used_stat   (used_stat),
		.used_cnt    (used_cnt)
	);

	assign m_tdata = {(TDATA_W - SLOT_W - LEN_W)'(0), in_use, granted};

endmodule

@@ tb/ffra_checker.sv @@
module ffra_checker import ffra_pkg::*; #(
	parameter int MAX_RANGES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [TDATA_W-1:0]  s_tdata,
	input  logic [0:0]          s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [TDATA_W-1:0]  m_tdata,
	input  logic [STATUS_W-1:0] m_tuser,
	input  logic                cfg_we,
	input  logic [LEN_W-1:0]    cfg_data,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FREE_TBL = 0;
	localparam int USED_TBL = 1;

	typedef struct {
		status_t           status;
		logic [SLOT_W-1:0] granted_start;
		logic [LEN_W-1:0]  slots_in_use;
	} grant_t;

	int range_start [2][MAX_RANGES];
	int range_len [2][MAX_RANGES];
	int range_cnt [2];
	int slots_used;
	grant_t grant_q [$];

	task automatic rebuild_pool(input int capacity);
		range_start[FREE_TBL][0] = 0;
		range_len[FREE_TBL][0] = capacity > int'(MAX_CAP) ? int'(MAX_CAP) : capacity;
		range_cnt[FREE_TBL] = 1;
		range_cnt[USED_TBL] = 0;
		slots_used = 0;
	endtask

	function automatic int cut_change(input int t, input int i, input int s, input int n);
		int head;
		int tail;
		head = s - range_start[t][i];
		tail = range_start[t][i] + range_len[t][i] - (s + n);
		if (head == 0 && tail == 0) return -1;
		if (head > 0 && tail > 0) return 1;
		return 0;
	endfunction

	function automatic void remove_entry(input int t, input int p);
		for (int k = p; k + 1 < range_cnt[t]; k++) begin
			range_start[t][k] = range_start[t][k + 1];
			range_len[t][k] = range_len[t][k + 1];
		end
		range_cnt[t]--;
	endfunction

	function automatic void add_entry(input int t, input int p, input int s, input int n);
		for (int k = range_cnt[t]; k > p; k--) begin
			range_start[t][k] = range_start[t][k - 1];
			range_len[t][k] = range_len[t][k - 1];
		end
		range_start[t][p] = s;
		range_len[t][p] = n;
		range_cnt[t]++;
	endfunction

	function automatic void cut_range(input int t, input int i, input int s, input int n);
		int head;
		int tail;
		head = s - range_start[t][i];
		tail = range_start[t][i] + range_len[t][i] - (s + n);
		if (head == 0 && tail == 0) begin
			remove_entry(t, i);
		end else if (head > 0 && tail > 0) begin
			range_len[t][i] = head;
			add_entry(t, i + 1, s + n, tail);
		end else if (head == 0) begin
			range_start[t][i] += n;
			range_len[t][i] -= n;
		end else begin
			range_len[t][i] -= n;
		end
	endfunction

	function automatic void plan_join(input int t, input int s, input int n, output int p,
			output bit join_lo, output bit join_hi, output int change);
		p = 0;
		while (p < range_cnt[t] && range_start[t][p] < s) p++;
		join_lo = p > 0 && range_start[t][p - 1] + range_len[t][p - 1] == s;
		join_hi = p < range_cnt[t] && s + n == range_start[t][p];
		change = (join_lo && join_hi) ? -1 : (!join_lo && !join_hi) ? 1 : 0;
	endfunction

	function automatic void join_range(input int t, input int p, input bit join_lo,
			input bit join_hi, input int s, input int n);
		if (join_lo && join_hi) begin
			range_len[t][p - 1] += n + range_len[t][p];
			remove_entry(t, p);
		end else if (join_lo) begin
			range_len[t][p - 1] += n;
		end else if (join_hi) begin
			range_start[t][p] -= n;
			range_len[t][p] += n;
		end else begin
			add_entry(t, p, s, n);
		end
	endfunction

	function automatic grant_t allocate(input logic op, input int s, input int n);
		grant_t g;
		int i;
		int p;
		int d_cut;
		int d_join;
		int entries;
		int src;
		int dst;
		bit join_lo;
		bit join_hi;
		g.status = STS_OK;
		g.granted_start = '0;
		entries = range_cnt[FREE_TBL] + range_cnt[USED_TBL];
		src = (op == OP_RESERVE) ? FREE_TBL : USED_TBL;
		dst = (op == OP_RESERVE) ? USED_TBL : FREE_TBL;
		i = 0;
		if (n == 0) begin
			g.status = STS_ZERO;
		end else begin
			if (op == OP_RESERVE) begin
				while (i < range_cnt[src] && range_len[src][i] < n) i++;
			end else begin
				while (i < range_cnt[src] && !(s >= range_start[src][i] &&
						s < range_start[src][i] + range_len[src][i])) i++;
			end
			if (i >= range_cnt[src]) begin
				g.status = (op == OP_RESERVE) ? STS_NO_FIT : STS_BAD_REL;
			end else if (op == OP_RELEASE && s + n > range_start[src][i] + range_len[src][i]) begin
				g.status = STS_BAD_REL;
			end else begin
				if (op == OP_RESERVE) s = range_start[src][i];
				d_cut = cut_change(src, i, s, n);
				plan_join(dst, s, n, p, join_lo, join_hi, d_join);
				if (entries + d_cut > MAX_RANGES || entries + d_cut + d_join > MAX_RANGES) begin
					g.status = STS_FULL;
				end else begin
					cut_range(src, i, s, n);
					join_range(dst, p, join_lo, join_hi, s, n);
					if (op == OP_RESERVE) begin
						slots_used += n;
						g.granted_start = s[SLOT_W-1:0];
					end else begin
						slots_used = slots_used >= n ? slots_used - n : 0;
					end
				end
			end
		end
		g.slots_in_use = slots_used[LEN_W-1:0];
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			rebuild_pool(int'(MAX_CAP));
			grant_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) rebuild_pool(int'(cfg_data));
			if (s_tvalid && s_tready)
				grant_q.push_back(allocate(s_tuser[0], int'(s_tdata[SLOT_W-1:0]),
					int'(s_tdata[SLOT_W +: LEN_W])));
			if (m_tvalid && m_tready) begin
				if (grant_q.size() == 0) begin
					$error("result item with none expected");
					errs++;
				end else begin
					want = grant_q.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						errs++;
					end
					if (m_tdata[SLOT_W-1:0] !== want.granted_start) begin
						$error("granted_start: expected %0d, got %0d", want.granted_start,
							m_tdata[SLOT_W-1:0]);
						errs++;
					end
					if (m_tdata[SLOT_W +: LEN_W] !== want.slots_in_use) begin
						$error("slots_in_use: expected %0d, got %0d", want.slots_in_use,
							m_tdata[SLOT_W +: LEN_W]);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
		pending <= grant_q.size();
	end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ffra_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 300;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;
	logic [0:0]         s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic               cfg_we;
	logic [LEN_W-1:0]   cfg_data;
	int                 fail_count;
	int                 pending;
	int                 cycles;
	int                 gap_pct;
	int                 stall_pct;
	int                 capacity;
	bit                 hold_go;

	first_fit_range_allocator u_top (.*);

	ffra_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send(input logic op, input int start, input int count);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {(TDATA_W - SLOT_W - LEN_W)'(0), count[LEN_W-1:0], start[SLOT_W-1:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic set_capacity(input int value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value[LEN_W-1:0];
		capacity = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(input int items, input int max_count);
		int start;
		int count;
		logic op;
		repeat (items) begin
			op = ($urandom_range(99) < 55) ? OP_RESERVE : OP_RELEASE;
			if ($urandom_range(99) < 4) count = 0;
			else if ($urandom_range(99) < 5) count = $urandom_range(65536);
			else count = $urandom_range(1, max_count);
			if (capacity > 0 && $urandom_range(99) < 85) start = $urandom_range(capacity - 1);
			else start = $urandom_range(65535);
			send(op, start, count);
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		hold_go = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		capacity = 65536;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_RESERVE, 0, 0);
		send(OP_RELEASE, 0, 0);
		send(OP_RESERVE, 65535, 65536);
		send(OP_RESERVE, 0, 1);
		send(OP_RELEASE, 0, 65536);
		send(OP_RESERVE, 12345, 100);
		send(OP_RESERVE, 0, 65536);
		send(OP_RELEASE, 50, 10);
		send(OP_RELEASE, 40, 20);
		send(OP_RELEASE, 65535, 1);
		send(OP_RESERVE, 0, 5);
		send(OP_RELEASE, 0, 50);
		send(OP_RELEASE, 60, 40);
		set_capacity(0);
		send(OP_RESERVE, 0, 1);
		send(OP_RELEASE, 0, 1);
		set_capacity(1);
		send(OP_RESERVE, 0, 1);
		send(OP_RESERVE, 0, 1);
		send(OP_RELEASE, 0, 1);
		set_capacity(65536);
		for (int k = 0; k < 40; k++) send(OP_RESERVE, 0, 1);
		for (int k = 0; k < 40; k += 2) send(OP_RELEASE, k, 1);

		set_capacity(96);
		hold_go = 1'b1;
		random_items(110, 3);
		gap_pct = 53;
		set_capacity(200);
		random_items(110, 8);
		gap_pct = 0;
		stall_pct = 53;
		set_capacity(65536);
		random_items(100, 4000);
		gap_pct = 12;
		stall_pct = 12;
		set_capacity(128);
		random_items(100, 4);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
